/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* src/ckt_pkg.sv */
`default_nettype none
package ckt_pkg;

    localparam int TABLE_ENTRIES = 16;

    localparam int S_DATA_W = 216;
    localparam int M_DATA_W = 8;

    localparam logic [1:0] KIND_REG     = 2'd0;
    localparam logic [1:0] KIND_UNREG   = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;
    localparam logic [1:0] KIND_PRESENT = 2'd3;

    typedef enum logic [2:0] {
        OP_REG     = 3'd0,
        OP_UNREG   = 3'd1,
        OP_QUERY   = 3'd2,
        OP_PRESENT = 3'd3,
        OP_INSERT  = 3'd4
    } t_op;

    // request token walking the cell row, with flags gathered on the way
    typedef struct packed {
        logic               valid;
        t_op                op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] rad;
        logic signed [27:0] cx;
        logic signed [27:0] cy;
        logic signed [27:0] cz;
        logic               match;
        logic               free_seen;
        logic               hit;
        logic               claimed;
    } t_tok;

endpackage
`default_nettype wire

/* src/ckt_cell.sv */
`default_nettype none
module ckt_cell
    import ckt_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok
);

    logic               r_valid;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] r_rad;
    t_tok               r_tok;

    t_tok               n_tok;
    logic               n_valid;
    logic               w_match;
    logic               w_claim;
    logic               w_upd_rad;
    logic signed [28:0] w_dx;
    logic signed [28:0] w_dy;
    logic signed [28:0] w_dz;
    logic [27:0]        w_ax;
    logic [27:0]        w_ay;
    logic [27:0]        w_az;
    logic [27:0]        w_dist;
    logic               w_hit;

    always_comb begin
        w_match = r_valid && (r_x == i_tok.x) && (r_y == i_tok.y) && (r_z == i_tok.z);
        w_claim = i_tok.valid && (i_tok.op == OP_INSERT) && !r_valid && !i_tok.claimed;
        w_upd_rad = i_tok.valid && (i_tok.op == OP_REG) && w_match;

        // chunk position is the block position shifted right by 4 (floor)
        w_dx = {i_tok.cx[27], i_tok.cx} - {r_x[31], r_x[31:4]};
        w_dy = {i_tok.cy[27], i_tok.cy} - {r_y[31], r_y[31:4]};
        w_dz = {i_tok.cz[27], i_tok.cz} - {r_z[31], r_z[31:4]};
        w_ax = w_dx[28] ? 28'(-w_dx) : w_dx[27:0];
        w_ay = w_dy[28] ? 28'(-w_dy) : w_dy[27:0];
        w_az = w_dz[28] ? 28'(-w_dz) : w_dz[27:0];
        w_dist = w_ax;
        if (w_ay > w_dist) begin
            w_dist = w_ay;
        end
        if (w_az > w_dist) begin
            w_dist = w_az;
        end
        w_hit = r_valid && !r_rad[31] && ({4'd0, w_dist} <= r_rad[31:0]);

        n_valid = r_valid;
        if (i_tok.valid && (i_tok.op == OP_UNREG) && w_match) begin
            n_valid = 1'b0;
        end else if (w_claim) begin
            n_valid = 1'b1;
        end

        n_tok = i_tok;
        n_tok.match     = i_tok.match | w_match;
        n_tok.free_seen = i_tok.free_seen | !r_valid;
        n_tok.hit       = i_tok.hit | w_hit;
        n_tok.claimed   = i_tok.claimed | w_claim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_x   <= i_tok.x;
            r_y   <= i_tok.y;
            r_z   <= i_tok.z;
            r_rad <= i_tok.rad;
        end else if (w_upd_rad) begin
            r_rad <= i_tok.rad;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

/* src/chebyshev_keepalive_table.sv */
// Path: an accepted word is registered into the injection slot, and its request token then
//   steps through one cell per cycle; a register of a new point that finds a free slot walks the row twice.
// Flow: no new word is accepted until the result of the current one has been taken into the
//   output register, which waits in a hold state while the output is stalled.
// Reset: synchronous, active low; all entry valid bits clear together, no sweep.
`default_nettype none
`include "assert_macros.svh"
module chebyshev_keepalive_table
    import ckt_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // block_x, block_y, block_z, keep_radius, chunk_x, chunk_y, chunk_z, pad
    input  wire [S_DATA_W-1:0]   i_s_axis_tdata,
    // kind
    input  wire [1:0]            i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    // can_unload, is_present, table_full, pad
    output logic [M_DATA_W-1:0]  o_m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    t_state      r_state, n_state;
    t_tok        r_inj, n_inj;
    logic        r_m_valid, n_m_valid;
    logic [2:0]  r_m_data, n_m_data;
    logic [2:0]  r_res, n_res;

    t_tok        w_tok [TABLE_ENTRIES+1];
    t_tok        w_end;
    logic [2:0]  w_res;
    logic [TABLE_ENTRIES:0] w_tok_vld;

    assign w_tok[0] = r_inj;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            ckt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
        for (g = 0; g <= TABLE_ENTRIES; g++) begin : g_vld
            assign w_tok_vld[g] = w_tok[g].valid;
        end
    endgenerate

    assign w_end = w_tok[TABLE_ENTRIES];

    // bit 0 can_unload, bit 1 is_present, bit 2 table_full
    always_comb begin
        w_res[0] = (w_end.op == OP_QUERY) && !w_end.hit;
        w_res[1] = (w_end.op == OP_PRESENT) && w_end.match;
        w_res[2] = (w_end.op == OP_REG) && !w_end.match && !w_end.free_seen;
    end

    always_comb begin
        n_state   = r_state;
        n_inj     = r_inj;
        n_inj.valid = 1'b0;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_data  = r_m_data;
        n_res     = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_inj.valid = 1'b1;
                    case (i_s_axis_tuser)
                        KIND_REG:   n_inj.op = OP_REG;
                        KIND_UNREG: n_inj.op = OP_UNREG;
                        KIND_QUERY: n_inj.op = OP_QUERY;
                        default:    n_inj.op = OP_PRESENT;
                    endcase
                    n_inj.x   = i_s_axis_tdata[31:0];
                    n_inj.y   = i_s_axis_tdata[63:32];
                    n_inj.z   = i_s_axis_tdata[95:64];
                    n_inj.rad = i_s_axis_tdata[127:96];
                    n_inj.cx  = i_s_axis_tdata[155:128];
                    n_inj.cy  = i_s_axis_tdata[183:156];
                    n_inj.cz  = i_s_axis_tdata[211:184];
                    n_inj.match     = 1'b0;
                    n_inj.free_seen = 1'b0;
                    n_inj.hit       = 1'b0;
                    n_inj.claimed   = 1'b0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_end.valid) begin
                    if ((w_end.op == OP_REG) && !w_end.match && w_end.free_seen) begin
                        // no such point stored: second pass claims the lowest free cell
                        n_inj           = w_end;
                        n_inj.op        = OP_INSERT;
                        n_inj.match     = 1'b0;
                        n_inj.free_seen = 1'b0;
                        n_inj.hit       = 1'b0;
                        n_inj.claimed   = 1'b0;
                    end else if (!r_m_valid || i_m_axis_tready) begin
                        n_m_valid = 1'b1;
                        n_m_data  = w_res;
                        n_state   = S_IDLE;
                    end else begin
                        n_res   = w_res;
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inj.valid <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_inj     <= n_inj;
            r_m_valid <= n_m_valid;
            r_m_data  <= n_m_data;
            r_res     <= n_res;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {5'd0, r_m_data};

    `ASSERT_ALWAYS(a_one_token, i_clk, i_rst_n, $countones(w_tok_vld) <= 1, "more than one token in the cell row")
    `ASSERT_ALWAYS(a_end_in_run, i_clk, i_rst_n, !w_end.valid || (r_state == S_RUN), "token left the row outside RUN")
    `ASSERT_ALWAYS(a_one_flag, i_clk, i_rst_n, !r_m_valid || ($countones(r_m_data) <= 1), "result word has more than one flag set")
    `ASSERT_NEVER(a_accept_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && (w_tok_vld != '0), "word accepted while a token is in flight")

endmodule
`default_nettype wire
